/* rtl/core/world_to_pixel_dda_line_plotter_unit_macros.svh */
// Assertion macros for the world-to-pixel line plotter.
// Used by the top level; relies on signals named clock and reset in scope.
`ifndef WORLD_TO_PIXEL_DDA_LINE_PLOTTER_UNIT_MACROS_SVH
`define WORLD_TO_PIXEL_DDA_LINE_PLOTTER_UNIT_MACROS_SVH

// Same-cycle implication.
`define WPD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("plotter check failed");

// Next-cycle implication.
`define WPD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("plotter check failed");

`endif

/* rtl/core/wpd_pkg.sv */
// Shared types, constants and helper functions of the world-to-pixel plotter.
// No dependencies.
package wpd_pkg;

   localparam logic [6:0] MAX_COLUMNS = 7'd64;
   localparam logic [6:0] MAX_ROWS    = 7'd64;

   localparam int DIV_W = 41;
   localparam int QUO_W = 17;
   localparam int CNT_W = 5;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;   // divisor already shifted to the top quotient bit
      logic [CNT_W-1:0] count;     // number of quotient bits
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [6:0] eff_size(input logic [6:0] v, input logic [6:0] maxv);
      logic [6:0] r;
      if (v < 7'd2) r = 7'd2;
      else if (v > maxv) r = maxv;
      else r = v;
      return r;
   endfunction

   // Round a Q6.16 position to a pixel, clamped to 0 and size - 1.
   function automatic logic [5:0] pos_to_pixel(input logic signed [22:0] pos,
                                               input logic [6:0] n);
      logic [22:0] sum;
      logic [6:0]  p;
      sum = 23'(pos) + 23'd32768;
      if (pos[22]) p = 7'd0;
      else p = sum[22:16];
      if (p > n - 7'd1) p = n - 7'd1;
      return p[5:0];
   endfunction

endpackage

/* rtl/core/wpd_divider.sv */
// Restoring divider, one quotient bit per cycle, shared by every division.
// Depends on wpd_pkg.
module wpd_divider
   import wpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [QUO_W-1:0] quo_ff, quo_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.count;
         rem_in  = req.dividend;
         dvs_in  = req.divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (rem_ff >= dvs_ff) begin
            rem_in = rem_ff - dvs_ff;
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

/* rtl/core/world_to_pixel_dda_line_plotter_unit.sv */
// Top level of the world-to-pixel point and DDA line plotter.
// Depends on wpd_pkg, wpd_divider and the assertion macro header.
//
//   channel  ports            direction  moves
//   req      req_valid/stall  in         one point or line item
//   rsp      rsp_valid/stall  out        one pixel write item
//   csr      csr_write        in         one register write, no read-back
//
// One divider does all the work, one quotient bit per cycle.
// A point goes through the check and two 6-bit mapping divisions.
// A line goes through four 6-bit mapping divisions, two
// 17-bit increment divisions, then one DDA step per output item; the
// line length in pixels is up to 63.
// Reset is synchronous; it clears control state and loads the register reset values.
// An output stall holds the DDA stepper; a new item is taken only when idle.
`include "world_to_pixel_dda_line_plotter_unit_macros.svh"
module world_to_pixel_dda_line_plotter_unit
   import wpd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_end_x,
   input  logic signed [31:0] req_end_y,
   input  logic        [7:0]  req_glyph,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [5:0]  rsp_pixel_row,
   output logic        [5:0]  rsp_pixel_column,
   output logic        [7:0]  rsp_pixel_glyph,
   output logic               rsp_last_write,
   input  logic               csr_write,
   input  logic        [2:0]  csr_index,
   input  logic        [31:0] csr_data
);

   // Register indexes.
   localparam logic [2:0] REG_X_LOW   = 3'd0;
   localparam logic [2:0] REG_X_HIGH  = 3'd1;
   localparam logic [2:0] REG_Y_LOW   = 3'd2;
   localparam logic [2:0] REG_Y_HIGH  = 3'd3;
   localparam logic [2:0] REG_COLUMNS = 3'd4;
   localparam logic [2:0] REG_ROWS    = 3'd5;

   // Sequencer states.
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_MLOAD = 4'd2;
   localparam logic [3:0] S_MWAIT = 4'd3;
   localparam logic [3:0] S_POINT = 4'd4;
   localparam logic [3:0] S_EVAL  = 4'd5;
   localparam logic [3:0] S_ILOAD = 4'd6;
   localparam logic [3:0] S_IWAIT = 4'd7;
   localparam logic [3:0] S_STEP  = 4'd8;

   // Endpoint coordinate slots, mapped in this order.
   localparam logic [1:0] K_START_X = 2'd0;
   localparam logic [1:0] K_START_Y = 2'd1;
   localparam logic [1:0] K_END_X   = 2'd2;
   localparam logic [1:0] K_END_Y   = 2'd3;

   // Configuration registers.
   logic signed [31:0] x_low_ff, x_high_ff, y_low_ff, y_high_ff;
   logic        [6:0]  columns_ff, rows_ff;

   // Item registers.
   logic               op_ff, op_in;
   logic signed [31:0] sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic        [7:0]  glyph_ff, glyph_in;

   // Sequencer and datapath state.
   logic        [3:0]  state_ff, state_in;
   logic        [1:0]  k_ff, k_in;
   logic        [5:0]  sc_ff, sc_in, sr_ff, sr_in, ec_ff, ec_in, er_ff, er_in;
   logic        [5:0]  len_ff, len_in;
   logic        [6:0]  steps_left_ff, steps_left_in;
   logic signed [22:0] col_pos_ff, col_pos_in, row_pos_ff, row_pos_in;
   logic signed [17:0] col_step_ff, col_step_in, row_step_ff, row_step_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic        [5:0]  out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic        [7:0]  out_glyph_ff, out_glyph_in;
   logic               out_last_ff, out_last_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [6:0] nc, nr;
   logic       out_free;

   // Mapping operands.
   logic signed [31:0] m_v, m_lo, m_hi;
   logic        [6:0]  m_n;
   logic        [32:0] m_diff_w, m_den_w;
   logic        [37:0] m_num;
   logic        [5:0]  m_q, m_nm1;

   // Increment operands.
   logic signed [6:0]  dc, dr, i_d;
   logic        [5:0]  adc, adr, i_ad, len_w;
   logic               i_neg;
   logic        [17:0] i_mag;

   // DDA step.
   logic signed [22:0] col_next, row_next;

   function automatic logic in_window(input logic signed [31:0] v,
                                      input logic signed [31:0] lo,
                                      input logic signed [31:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

   assign nc       = eff_size(columns_ff, MAX_COLUMNS);
   assign nr       = eff_size(rows_ff, MAX_ROWS);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Select the coordinate under mapping; odd slots are y.
   always_comb begin
      unique case (k_ff)
         K_START_X: m_v = sx_ff;
         K_START_Y: m_v = sy_ff;
         K_END_X:   m_v = ex_ff;
         K_END_Y:   m_v = ey_ff;
         default:   m_v = sx_ff;
      endcase
      m_lo     = k_ff[0] ? y_low_ff  : x_low_ff;
      m_hi     = k_ff[0] ? y_high_ff : x_high_ff;
      m_n      = k_ff[0] ? nr : nc;
      m_nm1    = 6'(m_n - 7'd1);
      m_diff_w = 33'({m_v[31], m_v} - {m_lo[31], m_lo});
      m_den_w  = 33'({m_hi[31], m_hi} - {m_lo[31], m_lo});
      m_num    = {6'b0, m_diff_w[31:0]} * {32'b0, m_nm1};
      // Flip rows so that row 0 is the top.
      m_q      = k_ff[0] ? 6'(m_nm1 - div_rsp.quotient[5:0]) : div_rsp.quotient[5:0];
   end

   always_comb begin
      dc    = $signed({1'b0, ec_ff}) - $signed({1'b0, sc_ff});
      dr    = $signed({1'b0, er_ff}) - $signed({1'b0, sr_ff});
      adc   = dc[6] ? 6'(-dc) : dc[5:0];
      adr   = dr[6] ? 6'(-dr) : dr[5:0];
      len_w = (adc > adr) ? adc : adr;
      i_d   = k_ff[0] ? dr : dc;
      i_ad  = k_ff[0] ? adr : adc;
      i_neg = i_d[6];
      i_mag = {1'b0, div_rsp.quotient};
   end

   assign col_next = col_pos_ff + {{5{col_step_ff[17]}}, col_step_ff};
   assign row_next = row_pos_ff + {{5{row_step_ff[17]}}, row_step_ff};

   // Feed the shared divider from the load states.
   always_comb begin
      div_req = '0;
      if (state_ff == S_MLOAD) begin
         div_req.start    = 1'b1;
         div_req.dividend = {2'b0, m_num, 1'b0} + {9'b0, m_den_w[31:0]};
         div_req.divisor  = {3'b0, m_den_w[31:0], 6'b0};
         div_req.count    = CNT_W'(6);
      end else if (state_ff == S_ILOAD) begin
         // Floor division of a negative numerator: bias by divisor - 1.
         div_req.start    = 1'b1;
         div_req.dividend = {18'b0, i_ad, 17'b0} + {35'b0, len_ff} - {40'b0, i_neg};
         div_req.divisor  = {18'b0, len_ff, 17'b0};
         div_req.count    = CNT_W'(QUO_W);
      end
   end

   wpd_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      op_in         = op_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      ex_in         = ex_ff;
      ey_in         = ey_ff;
      glyph_in      = glyph_ff;
      sc_in         = sc_ff;
      sr_in         = sr_ff;
      ec_in         = ec_ff;
      er_in         = er_ff;
      len_in        = len_ff;
      steps_left_in = steps_left_ff;
      col_pos_in    = col_pos_ff;
      row_pos_in    = row_pos_ff;
      col_step_in   = col_step_ff;
      row_step_in   = row_step_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      out_glyph_in  = out_glyph_ff;
      out_last_in   = out_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               sx_in    = req_start_x;
               sy_in    = req_start_y;
               ex_in    = req_end_x;
               ey_in    = req_end_y;
               glyph_in = req_glyph;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // Drop the item on a degenerate window or an endpoint outside.
            if ((x_high_ff > x_low_ff) && (y_high_ff > y_low_ff) &&
                in_window(sx_ff, x_low_ff, x_high_ff) &&
                in_window(sy_ff, y_low_ff, y_high_ff) &&
                (!op_ff || (in_window(ex_ff, x_low_ff, x_high_ff) &&
                            in_window(ey_ff, y_low_ff, y_high_ff)))) begin
               k_in     = K_START_X;
               state_in = S_MLOAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MLOAD: state_in = S_MWAIT;
         S_MWAIT: begin
            if (div_rsp.done) begin
               unique case (k_ff)
                  K_START_X: sc_in = m_q;
                  K_START_Y: sr_in = m_q;
                  K_END_X:   ec_in = m_q;
                  K_END_Y:   er_in = m_q;
                  default:   sc_in = m_q;
               endcase
               if (k_ff == K_END_Y) begin
                  state_in = S_EVAL;
               end else if (k_ff == K_START_Y && !op_ff) begin
                  state_in = S_POINT;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_MLOAD;
               end
            end
         end
         S_POINT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_row_in   = sr_ff;
               out_col_in   = sc_ff;
               out_glyph_in = glyph_ff;
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_EVAL: begin
            if (len_w == 6'd0) begin
               state_in = S_IDLE;
            end else begin
               len_in        = len_w;
               steps_left_in = {1'b0, len_w};
               col_pos_in    = $signed({1'b0, sc_ff, 16'b0});
               row_pos_in    = $signed({1'b0, sr_ff, 16'b0});
               k_in          = 2'd0;
               state_in      = S_ILOAD;
            end
         end
         S_ILOAD: state_in = S_IWAIT;
         S_IWAIT: begin
            if (div_rsp.done) begin
               if (k_ff[0]) begin
                  row_step_in = i_neg ? $signed(18'(-i_mag)) : $signed(i_mag);
                  state_in    = S_STEP;
               end else begin
                  col_step_in = i_neg ? $signed(18'(-i_mag)) : $signed(i_mag);
                  k_in        = 2'd1;
                  state_in    = S_ILOAD;
               end
            end
         end
         S_STEP: begin
            // Advance one DDA step per free output slot.
            if (out_free) begin
               col_pos_in    = col_next;
               row_pos_in    = row_next;
               steps_left_in = steps_left_ff - 7'd1;
               rsp_valid_in  = 1'b1;
               out_row_in    = pos_to_pixel(row_next, nr);
               out_col_in    = pos_to_pixel(col_next, nc);
               out_glyph_in  = glyph_ff;
               out_last_in   = (steps_left_ff == 7'd1);
               if (steps_left_ff == 7'd1) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         k_ff          <= '0;
         steps_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         x_low_ff      <= 32'sd0;
         x_high_ff     <= 32'sd4128768;
         y_low_ff      <= 32'sd0;
         y_high_ff     <= 32'sd4128768;
         columns_ff    <= 7'd64;
         rows_ff       <= 7'd64;
      end else begin
         state_ff      <= state_in;
         k_ff          <= k_in;
         steps_left_ff <= steps_left_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               REG_X_LOW:   x_low_ff   <= $signed(csr_data);
               REG_X_HIGH:  x_high_ff  <= $signed(csr_data);
               REG_Y_LOW:   y_low_ff   <= $signed(csr_data);
               REG_Y_HIGH:  y_high_ff  <= $signed(csr_data);
               REG_COLUMNS: columns_ff <= csr_data[6:0];
               REG_ROWS:    rows_ff    <= csr_data[6:0];
               default:     ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      ex_ff        <= ex_in;
      ey_ff        <= ey_in;
      glyph_ff     <= glyph_in;
      sc_ff        <= sc_in;
      sr_ff        <= sr_in;
      ec_ff        <= ec_in;
      er_ff        <= er_in;
      len_ff       <= len_in;
      col_pos_ff   <= col_pos_in;
      row_pos_ff   <= row_pos_in;
      col_step_ff  <= col_step_in;
      row_step_ff  <= row_step_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_glyph_ff <= out_glyph_in;
      out_last_ff  <= out_last_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_row    = out_row_ff;
   assign rsp_pixel_column = out_col_ff;
   assign rsp_pixel_glyph  = out_glyph_ff;
   assign rsp_last_write   = out_last_ff;

   `WPD_ASSERT_SAME(step_count_live, state_ff == S_STEP, steps_left_ff != 7'd0)
   `WPD_ASSERT_NEXT(accept_starts_check, req_valid && !req_stall, state_ff == S_CHECK)
   `WPD_ASSERT_SAME(divider_only_waiting, div_rsp.busy, (state_ff == S_MWAIT) || (state_ff == S_IWAIT))

endmodule

/* dv/tb_world_to_pixel_dda_line_plotter_unit.sv */
// Self-checking testbench for the world-to-pixel point and DDA line plotter.
// Depends on wpd_pkg and the RTL top level world_to_pixel_dda_line_plotter_unit.
module tb_world_to_pixel_dda_line_plotter_unit
   import wpd_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // Operation and register codes
   localparam logic OP_POINT = 1'b0;
   localparam logic OP_LINE  = 1'b1;
   localparam logic [2:0] REG_X_LOW   = 3'd0;
   localparam logic [2:0] REG_X_HIGH  = 3'd1;
   localparam logic [2:0] REG_Y_LOW   = 3'd2;
   localparam logic [2:0] REG_Y_HIGH  = 3'd3;
   localparam logic [2:0] REG_COLUMNS = 3'd4;
   localparam logic [2:0] REG_ROWS    = 3'd5;
   localparam int IDLE_CYCLES = 200;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] sx, sy, ex, ey;
      logic        [7:0]  glyph;
   } shape_type;

   typedef struct packed {
      logic [5:0] row, column;
      logic [7:0] glyph;
      logic       last;
   } pixel_type;

   logic clock, reset;
   logic req_valid, req_stall, req_opcode;
   logic signed [31:0] req_start_x, req_start_y, req_end_x, req_end_y;
   logic [7:0] req_glyph;
   logic rsp_valid, rsp_stall, rsp_last_write;
   logic [5:0] rsp_pixel_row, rsp_pixel_column;
   logic [7:0] rsp_pixel_glyph;
   logic csr_write;
   logic [2:0] csr_index;
   logic [31:0] csr_data;

   world_to_pixel_dda_line_plotter_unit dut (.*);

   // Model copy of the registers
   logic signed [31:0] win_xl, win_xh, win_yl, win_yh;
   logic [6:0] cols_reg, rows_reg;

   shape_type shape_queue[$];
   pixel_type pixel_queue[$];
   int sender_idle_pct, receiver_stall_pct;
   int errors, shapes_sent, pixels_seen;
   longint cycle;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Map one axis to a pixel index with half-up rounding; returns 0 if outside.
   function automatic bit map_axis(input longint v, input longint lo, input longint hi,
                                   input int n, output int idx);
      longint num, den;
      idx = 0;
      if (v < lo || v > hi) return 0;
      num = (v - lo) * (n - 1);
      den = hi - lo;
      idx = int'((2 * num + den) / (2 * den));
      return 1;
   endfunction

   function automatic longint floor_quot(input longint a, input longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic int stepped_pixel(input logic signed [22:0] pos, input int n);
      longint p;
      p = (pos < 0) ? 0 : longint'(pos);
      p = (p + 32768) >>> 16;
      if (p > n - 1) p = n - 1;
      return int'(p);
   endfunction

   // Queue one shape for the driver.
   task automatic add_shape(input shape_type s);
      shape_queue.insert(shape_queue.size(), s);
   endtask

   // Append the pixel writes that one shape produces.
   task automatic predict_pixels(input shape_type s);
      int nc, nr, sc, sr, ec, er, dc, dr, len, k;
      longint cs, rs;
      logic signed [22:0] cpos, rpos;
      pixel_type px;
      nc = (cols_reg < 2) ? 2 : (cols_reg > MAX_COLUMNS) ? int'(MAX_COLUMNS) : cols_reg;
      nr = (rows_reg < 2) ? 2 : (rows_reg > MAX_ROWS) ? int'(MAX_ROWS) : rows_reg;
      if (win_xh <= win_xl || win_yh <= win_yl) return;
      if (!map_axis(s.sx, win_xl, win_xh, nc, sc)) return;
      if (!map_axis(s.sy, win_yl, win_yh, nr, sr)) return;
      sr = nr - 1 - sr;
      if (s.opcode == OP_POINT) begin
         px = '{row: sr[5:0], column: sc[5:0], glyph: s.glyph, last: 1'b1};
         pixel_queue.insert(pixel_queue.size(), px);
         return;
      end
      if (!map_axis(s.ex, win_xl, win_xh, nc, ec)) return;
      if (!map_axis(s.ey, win_yl, win_yh, nr, er)) return;
      er = nr - 1 - er;
      dc = ec - sc;
      dr = er - sr;
      len = (dc < 0 ? -dc : dc) > (dr < 0 ? -dr : dr) ? (dc < 0 ? -dc : dc) : (dr < 0 ? -dr : dr);
      if (len == 0) return;
      cs = floor_quot(longint'(dc) * 131072 + len, 2 * longint'(len));
      rs = floor_quot(longint'(dr) * 131072 + len, 2 * longint'(len));
      cpos = 23'(sc) << 16;
      rpos = 23'(sr) << 16;
      for (k = len - 1; k >= 0; k--) begin
         cpos = cpos + 23'(cs);
         rpos = rpos + 23'(rs);
         px.row = 6'(stepped_pixel(rpos, nr));
         px.column = 6'(stepped_pixel(cpos, nc));
         px.glyph = s.glyph;
         px.last = (k == 0);
         pixel_queue.insert(pixel_queue.size(), px);
      end
   endtask

   // Driver: present queued shapes, hold while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (shape_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            shape_type s;
            s = shape_queue.pop_front();
            req_valid   <= 1'b1;
            req_opcode  <= s.opcode;
            req_start_x <= s.sx;
            req_start_y <= s.sy;
            req_end_x   <= s.ex;
            req_end_y   <= s.ey;
            req_glyph   <= s.glyph;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Predict on acceptance; the register copy is stable while items flow.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_pixels({req_opcode, req_start_x, req_start_y, req_end_x, req_end_y,
                         req_glyph});
         shapes_sent++;
      end
   end

   // Monitor: compare each accepted pixel write with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         pixels_seen++;
         if (pixel_queue.size() == 0) begin
            $error("unexpected pixel write row=%0d column=%0d", rsp_pixel_row,
                   rsp_pixel_column);
            errors++;
         end else begin
            pixel_type e;
            e = pixel_queue.pop_front();
            if (rsp_pixel_row !== e.row) begin
               $error("pixel_row expected %0d got %0d", e.row, rsp_pixel_row); errors++;
            end
            if (rsp_pixel_column !== e.column) begin
               $error("pixel_column expected %0d got %0d", e.column, rsp_pixel_column);
               errors++;
            end
            if (rsp_pixel_glyph !== e.glyph) begin
               $error("pixel_glyph expected %0d got %0d", e.glyph, rsp_pixel_glyph);
               errors++;
            end
            if (rsp_last_write !== e.last) begin
               $error("last_write expected %0d got %0d", e.last, rsp_last_write);
               errors++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Cycle limit
   always @(posedge clock) begin
      cycle++;
      if (cycle > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_X_LOW:   win_xl = val;
         REG_X_HIGH:  win_xh = val;
         REG_Y_LOW:   win_yl = val;
         REG_Y_HIGH:  win_yh = val;
         REG_COLUMNS: cols_reg = val[6:0];
         REG_ROWS:    rows_reg = val[6:0];
         default: ;
      endcase
   endtask

   task automatic set_window(input logic [31:0] xl, xh, yl, yh, input logic [6:0] c, r);
      write_reg(REG_X_LOW, xl);
      write_reg(REG_X_HIGH, xh);
      write_reg(REG_Y_LOW, yl);
      write_reg(REG_Y_HIGH, yh);
      write_reg(REG_COLUMNS, 32'(c));
      write_reg(REG_ROWS, 32'(r));
   endtask

   // Wait until every queued shape is taken and every pixel has come, then idle.
   task automatic drain();
      while (shape_queue.size() > 0 || req_valid || pixel_queue.size() > 0)
         @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      return $urandom();
   endfunction

   // Coordinate mostly inside the window, sometimes on an edge or outside.
   function automatic logic signed [31:0] pick_coord(input logic signed [31:0] lo, hi);
      longint span;
      int sel;
      sel = $urandom_range(99);
      span = longint'(hi) - longint'(lo);
      if (span <= 0 || sel < 5) return rand_word();
      if (sel < 10) return lo;
      if (sel < 15) return hi;
      if (sel < 20) return 32'(longint'(hi) + 1 + $urandom_range(1000));
      return 32'(longint'(lo) + ((longint'($urandom()) << 20 ^ $urandom()) % (span + 1)));
   endfunction

   function automatic shape_type random_shape();
      shape_type s;
      s.opcode = ($urandom_range(3) != 0) ? OP_LINE : OP_POINT;
      s.sx = pick_coord(win_xl, win_xh);
      s.sy = pick_coord(win_yl, win_yh);
      s.ex = pick_coord(win_xl, win_xh);
      s.ey = pick_coord(win_yl, win_yh);
      s.glyph = $urandom_range(255);
      return s;
   endfunction

   task automatic run_random(input int n, input int idle_pct, input int stall_pct);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (n) add_shape(random_shape());
      drain();
   endtask

   initial begin
      logic signed [31:0] q63;
      errors = 0; shapes_sent = 0; pixels_seen = 0; cycle = 0;
      sender_idle_pct = 0; receiver_stall_pct = 0;
      reset = 1'b1; req_valid = 1'b0; rsp_stall = 1'b0; csr_write = 1'b0;
      csr_index = REG_X_LOW; csr_data = '0;
      req_opcode = OP_POINT; req_start_x = '0; req_start_y = '0;
      req_end_x = '0; req_end_y = '0; req_glyph = '0;
      win_xl = 0; win_xh = 32'sd4128768; win_yl = 0; win_yh = 32'sd4128768;
      cols_reg = 7'd64; rows_reg = 7'd64;
      q63 = 32'sd4128768;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: corners, edges, long diagonals, zero length, outside ends.
      add_shape('{OP_POINT, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 8'h00});
      add_shape('{OP_POINT, q63, q63, 32'sd0, 32'sd0, 8'hFF});
      add_shape('{OP_POINT, 32'sd32768, 32'sd32768, 32'sd0, 32'sd0, 8'h55});
      add_shape('{OP_POINT, -32'sd1, 32'sd0, 32'sd0, 32'sd0, 8'hAA});
      add_shape('{OP_POINT, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                  32'h80000000, 8'h11});
      add_shape('{OP_LINE, 32'sd0, 32'sd0, q63, q63, 8'h23});
      add_shape('{OP_LINE, q63, 32'sd0, 32'sd0, q63, 8'h24});
      add_shape('{OP_LINE, 32'sd0, 32'sd0, q63, 32'sd65536 * 5, 8'h25});
      add_shape('{OP_LINE, 32'sd65536 * 3, q63, 32'sd65536 * 4, 32'sd0, 8'h26});
      add_shape('{OP_LINE, 32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536, 8'h27});
      add_shape('{OP_LINE, 32'sd0, 32'sd0, q63 + 1, 32'sd0, 8'h28});
      add_shape('{OP_LINE, 32'sd65536 * 10, 32'sd65536 * 10, 32'sd65536 * 11,
                  32'sd65536 * 10, 8'h29});
      drain();

      // Extreme window and smallest canvas; sizes below range clamp to 2.
      set_window(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 7'd0, 7'd1);
      add_shape('{OP_LINE, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 8'h31});
      add_shape('{OP_POINT, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 8'h32});
      drain();
      // Oversize canvas clamps to the maximum; degenerate window emits nothing.
      set_window(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 7'd127, 7'd100);
      add_shape('{OP_LINE, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h80000000, 8'h33});
      drain();
      set_window(32'sd65536, 32'sd65536, 32'sd0, q63, 7'd64, 7'd64);
      add_shape('{OP_POINT, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 8'h34});
      drain();

      // Random phases across several register settings and idling mixes.
      set_window(32'sd0, q63, 32'sd0, q63, 7'd64, 7'd64);
      run_random(80, 0, 0);
      set_window(-32'sd655360, 32'sd1310720, -32'sd100, 32'sd9000000, 7'd17, 7'd40);
      run_random(80, 85, 0);
      set_window(32'h80000000, 32'h7FFFFFFF, 32'sd0, 32'sd65536, 7'd2, 7'd64);
      run_random(60, 0, 85);
      set_window(32'sd7, 32'sd300, -32'sd4128768, 32'sd4128768, 7'd64, 7'd3);
      run_random(80, 31, 31);
      // Sender pauses until all pixels have returned between items.
      set_window(32'sd0, q63, 32'sd0, q63, 7'd33, 7'd64);
      repeat (20) begin
         add_shape(random_shape());
         drain();
      end
      run_random(80, 0, 0);

      $display("Covered %0d shapes and %0d pixel writes over varied windows and canvases.",
               shapes_sent, pixels_seen);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/wpd_pkg.sv
rtl/core/wpd_divider.sv
rtl/core/world_to_pixel_dda_line_plotter_unit.sv
dv/tb_world_to_pixel_dda_line_plotter_unit.sv
